>>> sv/swtq_pkg.sv
`default_nettype none

package swtq_pkg;

    // fixed field widths of the stream payloads
    localparam int TICK_W      = 64;
    localparam int DUR_W       = 32;
    localparam int PRIO_W      = 6;
    localparam int IN_ID_W     = 8;
    localparam int OUT_ID_W    = 8;

    // slave-side tdata layout, lowest bit first
    localparam int IN_ID_LSB   = 0;
    localparam int DUR_LSB     = 8;
    localparam int PRIO_LSB    = 40;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;

    // tuser codes
    localparam logic ACT_SLEEP   = 1'b0;
    localparam logic ACT_TICK    = 1'b1;
    localparam logic KIND_WOKEN  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_TICK_RD,
        ST_TICK_CMP,
        ST_TICK_FIN
    } t_state;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_BEFORE,
        ALU_DUE
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [TICK_W-1:0]   a;
        logic [TICK_W-1:0]   b;
        logic [PRIO_W-1:0]   pa;
        logic [PRIO_W-1:0]   pb;
    } t_alu_req;

    typedef struct packed {
        logic [TICK_W-1:0]   sum;
        logic                flag;
    } t_alu_rsp;

endpackage

`default_nettype wire

>>> sv/swtq_entry_ram.sv
`default_nettype none

module swtq_entry_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 78
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/swtq_alu.sv
`default_nettype none

module swtq_alu (
    input  wire swtq_pkg::t_alu_req i_req,
    output swtq_pkg::t_alu_rsp      o_rsp
);

    logic [swtq_pkg::TICK_W-1:0] w_b_eff;
    logic                        w_cin;
    logic [swtq_pkg::TICK_W:0]   w_full;
    logic                        w_lt;
    logic                        w_eq;

    // one adder: a + b, or a - b for the compares
    always_comb begin
        w_b_eff = i_req.b;
        w_cin   = 1'b0;
        if (i_req.op != swtq_pkg::ALU_ADD) begin
            w_b_eff = ~i_req.b;
            w_cin   = 1'b1;
        end
        w_full = {1'b0, i_req.a} + {1'b0, w_b_eff} + {{swtq_pkg::TICK_W{1'b0}}, w_cin};
        w_lt   = ~w_full[swtq_pkg::TICK_W];
        w_eq   = (w_full[swtq_pkg::TICK_W-1:0] == '0);
    end

    always_comb begin
        o_rsp.sum = w_full[swtq_pkg::TICK_W-1:0];
        unique case (i_req.op)
            swtq_pkg::ALU_ADD:    o_rsp.flag = 1'b0;
            swtq_pkg::ALU_BEFORE: o_rsp.flag = w_eq ? (i_req.pa > i_req.pb) : w_lt;
            swtq_pkg::ALU_DUE:    o_rsp.flag = w_lt | w_eq;
            default:              o_rsp.flag = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/sorted_wakeup_timer_queue_top.sv
// channel   dir  fields (tdata low bit first)                      tuser        tlast
// s side    in   thread_id[7:0] sleep_ticks[39:8] prio[45:40] pad  action       -
// m side    out  woken_id[7:0]                                     event_kind   last
//
// sleep with zero duration: accepted and dropped, no result
// insert: walks tail to head, moving later entries up a slot; a full queue rejects
// tick: counter steps by one; due entries leave from the head, the last with tlast
// walks read one entry at a time through the single read port of the store
// reset clears state, counter, fill count, head and flags only; entries are not swept
// a waiting result holds the input off until it is taken; a tick walk pauses on it too
`default_nettype none

module sorted_wakeup_timer_queue_top #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // thread_id, sleep_ticks, thread_priority, zero pad
    input  wire logic [swtq_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // action
    input  wire logic                                i_s_tuser,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // woken_id
    output logic      [swtq_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // event_kind
    output logic                                     o_m_tuser,
    output logic                                     o_m_tlast
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TID_W = THREAD_ID_BITS;
    localparam int ENT_W = swtq_pkg::TICK_W + swtq_pkg::PRIO_W + TID_W;

    // queue is a ring: logical slot l lives at head + l, wrapped once
    function automatic logic [IDX_W-1:0] f_phys(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] lidx);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, lidx};
        if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            s = s - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    swtq_pkg::t_state r_state, n_state;

    logic [swtq_pkg::TICK_W-1:0]   r_tick, n_tick;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [IDX_W-1:0]              r_head, n_head;
    logic [CNT_W-1:0]              r_idx, n_idx;
    logic [swtq_pkg::TICK_W-1:0]   r_wake, n_wake;
    logic [swtq_pkg::PRIO_W-1:0]   r_prio, n_prio;
    logic [TID_W-1:0]              r_tid, n_tid;
    logic                          r_have, n_have;
    logic [TID_W-1:0]              r_pend_id, n_pend_id;
    logic                          r_out_valid, n_out_valid;
    logic [swtq_pkg::OUT_ID_W-1:0] r_out_id, n_out_id;
    logic                          r_out_kind, n_out_kind;
    logic                          r_out_last, n_out_last;

    // input fields
    logic [swtq_pkg::IN_ID_W-1:0]  w_id8;
    logic [swtq_pkg::DUR_W-1:0]    w_dur;
    logic [swtq_pkg::PRIO_W-1:0]   w_prio;
    logic [TID_W+7:0]              w_id_ext;
    logic [TID_W-1:0]              w_tid;
    logic [TID_W+7:0]              w_rej_ext;
    logic [TID_W+7:0]              w_pend_ext;

    // entry store
    logic                          w_we;
    logic                          w_re;
    logic [IDX_W-1:0]              w_waddr;
    logic [IDX_W-1:0]              w_raddr;
    logic [ENT_W-1:0]              w_wdata;
    logic [ENT_W-1:0]              w_rdata;
    logic [swtq_pkg::TICK_W-1:0]   w_rd_wake;
    logic [swtq_pkg::PRIO_W-1:0]   w_rd_prio;
    logic [TID_W-1:0]              w_rd_tid;

    swtq_pkg::t_alu_req            w_alu_req;
    swtq_pkg::t_alu_rsp            w_alu_rsp;

    logic                          w_out_free;
    logic                          w_in_acc;
    logic                          w_full;

    assign w_id8  = i_s_tdata[swtq_pkg::IN_ID_LSB +: swtq_pkg::IN_ID_W];
    assign w_dur  = i_s_tdata[swtq_pkg::DUR_LSB +: swtq_pkg::DUR_W];
    assign w_prio = i_s_tdata[swtq_pkg::PRIO_LSB +: swtq_pkg::PRIO_W];

    // identifier kept in its low TID_W bits, reported in 8 bits
    assign w_id_ext   = {{TID_W{1'b0}}, w_id8};
    assign w_tid      = w_id_ext[TID_W-1:0];
    assign w_rej_ext  = {8'b0, w_tid};
    assign w_pend_ext = {8'b0, r_pend_id};

    assign w_rd_wake = w_rdata[ENT_W-1 -: swtq_pkg::TICK_W];
    assign w_rd_prio = w_rdata[TID_W +: swtq_pkg::PRIO_W];
    assign w_rd_tid  = w_rdata[TID_W-1:0];

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == swtq_pkg::ST_IDLE) && w_out_free;
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == CNT_W'(QUEUE_DEPTH));

    // writes always land at logical slot r_idx
    assign w_waddr = f_phys(r_head, r_idx);

    swtq_entry_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (ENT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // operand select for the shared adder / comparator
    always_comb begin
        w_alu_req.pa = r_prio;
        w_alu_req.pb = w_rd_prio;
        unique case (r_state)
            swtq_pkg::ST_INS_CMP: begin
                w_alu_req.op = swtq_pkg::ALU_BEFORE;
                w_alu_req.a  = r_wake;
                w_alu_req.b  = w_rd_wake;
            end
            swtq_pkg::ST_TICK_CMP: begin
                w_alu_req.op = swtq_pkg::ALU_DUE;
                w_alu_req.a  = w_rd_wake;
                w_alu_req.b  = r_tick;
            end
            default: begin
                // tick increment or wake time of a new sleeper
                w_alu_req.op = swtq_pkg::ALU_ADD;
                w_alu_req.a  = r_tick;
                w_alu_req.b  = (i_s_tuser == swtq_pkg::ACT_TICK) ?
                               swtq_pkg::TICK_W'(1) :
                               {{(swtq_pkg::TICK_W - swtq_pkg::DUR_W){1'b0}}, w_dur};
            end
        endcase
    end

    swtq_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_tick      = r_tick;
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_wake      = r_wake;
        n_prio      = r_prio;
        n_tid       = r_tid;
        n_have      = r_have;
        n_pend_id   = r_pend_id;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_id    = r_out_id;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_raddr     = r_head;
        w_wdata     = {r_wake, r_prio, r_tid};

        unique case (r_state)
            swtq_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_s_tuser == swtq_pkg::ACT_TICK) begin
                        n_tick  = w_alu_rsp.sum;
                        n_have  = 1'b0;
                        n_state = swtq_pkg::ST_TICK_RD;
                    end else if (w_dur != '0) begin
                        if (w_full) begin
                            n_out_valid = 1'b1;
                            n_out_id    = w_rej_ext[7:0];
                            n_out_kind  = swtq_pkg::KIND_REJECT;
                            n_out_last  = 1'b1;
                        end else begin
                            n_wake  = w_alu_rsp.sum;
                            n_prio  = w_prio;
                            n_tid   = w_tid;
                            n_idx   = r_count;
                            n_state = swtq_pkg::ST_INS_RD;
                        end
                    end
                end
            end
            swtq_pkg::ST_INS_RD: begin
                // walk from the tail toward the head
                if (r_idx == '0) begin
                    w_we    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_state = swtq_pkg::ST_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = f_phys(r_head, r_idx - CNT_W'(1));
                    n_state = swtq_pkg::ST_INS_CMP;
                end
            end
            swtq_pkg::ST_INS_CMP: begin
                w_we = 1'b1;
                if (w_alu_rsp.flag) begin
                    // new entry goes ahead: move this one up a slot
                    w_wdata = w_rdata;
                    n_idx   = r_idx - CNT_W'(1);
                    n_state = swtq_pkg::ST_INS_RD;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    n_state = swtq_pkg::ST_IDLE;
                end
            end
            swtq_pkg::ST_TICK_RD: begin
                if (r_count == '0) begin
                    n_state = r_have ? swtq_pkg::ST_TICK_FIN : swtq_pkg::ST_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_head;
                    n_state = swtq_pkg::ST_TICK_CMP;
                end
            end
            swtq_pkg::ST_TICK_CMP: begin
                if (w_alu_rsp.flag) begin
                    // head is due; the held one is not last, so send it now
                    if (!r_have || w_out_free) begin
                        if (r_have) begin
                            n_out_valid = 1'b1;
                            n_out_id    = w_pend_ext[7:0];
                            n_out_kind  = swtq_pkg::KIND_WOKEN;
                            n_out_last  = 1'b0;
                        end
                        n_pend_id = w_rd_tid;
                        n_have    = 1'b1;
                        n_head    = (r_head == IDX_W'(QUEUE_DEPTH - 1)) ?
                                    '0 : r_head + IDX_W'(1);
                        n_count   = r_count - CNT_W'(1);
                        n_state   = swtq_pkg::ST_TICK_RD;
                    end
                end else begin
                    n_state = r_have ? swtq_pkg::ST_TICK_FIN : swtq_pkg::ST_IDLE;
                end
            end
            swtq_pkg::ST_TICK_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = w_pend_ext[7:0];
                    n_out_kind  = swtq_pkg::KIND_WOKEN;
                    n_out_last  = 1'b1;
                    n_have      = 1'b0;
                    n_state     = swtq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swtq_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swtq_pkg::ST_IDLE;
            r_tick      <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_count     <= n_count;
            r_head      <= n_head;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_wake     <= n_wake;
        r_prio     <= n_prio;
        r_tid      <= n_tid;
        r_pend_id  <= n_pend_id;
        r_out_id   <= n_out_id;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_id;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

>>> sv/swtq_checker.sv
`default_nettype none

module swtq_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_tvalid,
    input wire logic                            i_s_tready,
    input wire logic [swtq_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input wire logic                            i_s_tuser,
    input wire logic                            i_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [swtq_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input wire logic                            i_m_tuser,
    input wire logic                            i_m_tlast
);

    logic w_s_acc;
    logic w_zero_dur;

    assign w_s_acc    = i_s_tvalid && i_s_tready;
    assign w_zero_dur = (i_s_tdata[swtq_pkg::DUR_LSB +: swtq_pkg::DUR_W] == '0);

    // a tick always walks the queue, so the input side closes
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && i_s_tuser == swtq_pkg::ACT_TICK) |=> !i_s_tready)
        else $error("tick transaction did not drop ready");

    // a zero-length sleep leaves the block free unless the output is stalled
    a_zero_sleep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && i_s_tuser == swtq_pkg::ACT_SLEEP && w_zero_dur)
        |=> (i_s_tready || (i_m_tvalid && !i_m_tready)))
        else $error("zero-length sleep blocked the input side");

    // a rejection is always the only result of its request
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser == swtq_pkg::KIND_REJECT) |-> i_m_tlast)
        else $error("rejection without tlast");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tuser) && $stable(i_m_tlast)))
        else $error("stalled output transaction changed");

endmodule

bind sorted_wakeup_timer_queue_top swtq_checker u_swtq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);

`default_nettype wire

>>> sim/sorted_wakeup_timer_queue_top_tb.sv
`timescale 1ns / 100ps

module sorted_wakeup_timer_queue_top_tb;

    localparam int Q_DEPTH       = 16;
    localparam int ID_BITS       = 8;
    localparam int RANDOM_ITEMS  = 220;
    localparam int HOLD_AT       = 60;      // accepted transactions before the long stall
    localparam int HOLD_CYCLES   = 400;     // length of the long receiver stall
    localparam int SETTLE_CYCLES = 100;     // idle tail after the last owed result
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_PRINTS    = 30;

    // one sleep request or tick as offered on the slave side
    typedef struct {
        logic        action;
        logic [7:0]  id;
        logic [31:0] dur;
        logic [5:0]  prio;
        bit          drain_first;   // hold this one back until no result is outstanding
    } t_wake_req;

    // one result as seen on the master side
    typedef struct packed {
        logic       kind;
        logic [7:0] id;
        logic       last;
    } t_wake_event;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // dut ports, all inputs known from time zero
    logic                              i_s_tvalid = 1'b0;
    logic                              o_s_tready;
    logic [swtq_pkg::IN_TDATA_W-1:0]   i_s_tdata  = '0;   // thread_id, sleep_ticks, prio, pad
    logic                              i_s_tuser  = 1'b0; // action
    logic                              o_m_tvalid;
    logic                              i_m_tready = 1'b0;
    logic [swtq_pkg::OUT_TDATA_W-1:0]  o_m_tdata;         // woken_id
    logic                              o_m_tuser;         // event_kind
    logic                              o_m_tlast;

    sorted_wakeup_timer_queue_top #(
        .QUEUE_DEPTH    (Q_DEPTH),
        .THREAD_ID_BITS (ID_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // ------------------------------------------------------------------
    // timer queue predictor: own copy of counter and sorted sleeper list
    // ------------------------------------------------------------------
    logic [63:0] tick_now;
    logic [63:0] sleeper_wake [Q_DEPTH];
    logic [7:0]  sleeper_id   [Q_DEPTH];
    logic [5:0]  sleeper_prio [Q_DEPTH];
    int          sleeper_fill;

    t_wake_event pending_events[$];   // results still owed by the block
    t_wake_req   stim_q[$];           // transactions not yet offered

    // coverage tallies for the summary
    int n_ticks, n_sleeps, n_zero, n_rejects, n_wakes, longest_run;
    int n_errors;

    // updated only by their own process, with nonblocking writes
    int n_predicted, n_checked, n_accepted;
    int cycle_cnt;

    // applies one accepted transaction, queues what it should produce
    function automatic int predict_wakeups(t_wake_req r);
        logic [63:0] wake;
        logic [7:0]  rid;
        int          pos;
        int          due;
        int          i;
        rid = r.id & 8'((1 << ID_BITS) - 1);
        if (r.action == swtq_pkg::ACT_SLEEP) begin
            n_sleeps++;
            if (r.dur == '0) begin
                n_zero++;
                return 0;
            end
            if (sleeper_fill >= Q_DEPTH) begin
                pending_events.push_back('{swtq_pkg::KIND_REJECT, rid, 1'b1});
                n_rejects++;
                return 1;
            end
            wake = tick_now + {32'd0, r.dur};
            // walk past every entry that wakes earlier, or ties with equal or higher priority
            pos = 0;
            while (pos < sleeper_fill &&
                   !((wake == sleeper_wake[pos]) ? (r.prio > sleeper_prio[pos])
                                                 : (wake < sleeper_wake[pos])))
                pos++;
            for (i = sleeper_fill; i > pos; i--) begin
                sleeper_wake[i] = sleeper_wake[i-1];
                sleeper_id[i]   = sleeper_id[i-1];
                sleeper_prio[i] = sleeper_prio[i-1];
            end
            sleeper_wake[pos] = wake;
            sleeper_id[pos]   = rid;
            sleeper_prio[pos] = r.prio;
            sleeper_fill++;
            return 0;
        end
        n_ticks++;
        tick_now = tick_now + 64'd1;
        due = 0;
        while (due < sleeper_fill && sleeper_wake[due] <= tick_now)
            due++;
        for (i = 0; i < due; i++)
            pending_events.push_back('{swtq_pkg::KIND_WOKEN, sleeper_id[i], (i + 1 == due)});
        for (i = due; i < sleeper_fill; i++) begin
            sleeper_wake[i-due] = sleeper_wake[i];
            sleeper_id[i-due]   = sleeper_id[i];
            sleeper_prio[i-due] = sleeper_prio[i];
        end
        sleeper_fill -= due;
        n_wakes += due;
        if (due > longest_run)
            longest_run = due;
        return due;
    endfunction

    task automatic report_mismatch(string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endtask

    task automatic add_req(logic act, logic [7:0] id, logic [31:0] dur, logic [5:0] prio,
                           bit drain);
        stim_q.push_back('{act, id, dur, prio, drain});
    endtask

    task automatic add_tick(bit drain);
        add_req(swtq_pkg::ACT_TICK, 8'($urandom_range(0, 255)), $urandom,
                6'($urandom_range(0, 63)), drain);
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of transactions separated by random gaps
    // ------------------------------------------------------------------
    t_wake_req cur_req;
    int        burst_left = 1;
    int        gap_left   = 0;

    always @(posedge i_clk) begin
        int fresh;
        fresh = 0;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            // transaction taken at this edge goes straight into the predictor
            if (i_s_tvalid && o_s_tready) begin
                fresh = predict_wakeups(cur_req);
                n_predicted <= n_predicted + fresh;
                n_accepted  <= n_accepted + 1;
            end
            if (i_s_tvalid && !o_s_tready) begin
                // offered but stalled: keep everything as it is
            end else if (gap_left > 0) begin
                i_s_tvalid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (stim_q.size() > 0 &&
                         (!stim_q[0].drain_first || n_predicted + fresh == n_checked)) begin
                cur_req    <= stim_q[0];
                i_s_tuser  <= stim_q[0].action;
                i_s_tdata  <= {2'b00, stim_q[0].prio, stim_q[0].dur, stim_q[0].id};
                i_s_tvalid <= 1'b1;
                void'(stim_q.pop_front());
                if (burst_left <= 1) begin
                    // about a third of the bursts run back to back with no gap
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: its own stall pattern plus one long hold-off
    // ------------------------------------------------------------------
    int  rx_mode      = 0;
    int  rx_mode_left = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (!hold_done && o_m_tvalid && n_accepted >= HOLD_AT) begin
            // block stays stuck on a result while the sender keeps pushing
            i_m_tready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(10, 80);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: begin
                    i_m_tready <= 1'b1;
                end
                1: begin
                    i_m_tready <= ($urandom_range(0, 1) == 1);
                end
                2: begin
                    i_m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    i_m_tready <= ($urandom_range(0, 7) != 0);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor: every result against the oldest outstanding prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_wake_event want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d id=0x%02h last=%0d",
                                          o_m_tuser, o_m_tdata, o_m_tlast));
            end else begin
                want = pending_events.pop_front();
                n_checked <= n_checked + 1;
                if (o_m_tuser !== want.kind)
                    report_mismatch($sformatf("event_kind %0d, predicted %0d",
                                              o_m_tuser, want.kind));
                if (o_m_tdata !== want.id)
                    report_mismatch($sformatf("woken_id 0x%02h, predicted 0x%02h",
                                              o_m_tdata, want.id));
                if (o_m_tlast !== want.last)
                    report_mismatch($sformatf("last %0d, predicted %0d (id 0x%02h)",
                                              o_m_tlast, want.last, want.id));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout: %0d of %0d results after %0d cycles",
                     n_checked, n_predicted, cycle_cnt);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int k;
        int seg_left;
        int tick_pct;
        tick_now     = '0;
        sleeper_fill = 0;
        seg_left     = 0;
        tick_pct     = 30;

        // directed: empty tick, zero length, widest fields
        add_req(swtq_pkg::ACT_TICK,  8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b0);
        add_req(swtq_pkg::ACT_SLEEP, 8'h00, 32'h0000_0000, 6'h00, 1'b0);
        add_req(swtq_pkg::ACT_SLEEP, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b0);  // never wakes here
        // equal wake ticks: higher priority first, full ties in arrival order
        add_req(swtq_pkg::ACT_SLEEP, 8'h10, 32'd2, 6'd5,  1'b0);
        add_req(swtq_pkg::ACT_SLEEP, 8'h11, 32'd2, 6'd40, 1'b0);
        add_req(swtq_pkg::ACT_SLEEP, 8'h12, 32'd2, 6'd5,  1'b0);
        add_req(swtq_pkg::ACT_SLEEP, 8'h13, 32'd1, 6'd0,  1'b0);
        add_req(swtq_pkg::ACT_SLEEP, 8'h14, 32'd3, 6'd63, 1'b0);
        // fill the queue to the brim
        for (k = 0; k < Q_DEPTH - 6; k++)
            add_req(swtq_pkg::ACT_SLEEP, 8'(8'h20 + k), 32'(1 + (k % 3)),
                    6'($urandom_range(0, 63)), 1'b0);
        // full queue rejects, but a zero length request is still just ignored
        add_req(swtq_pkg::ACT_SLEEP, 8'hA5, 32'd4, 6'd9, 1'b0);
        add_req(swtq_pkg::ACT_SLEEP, 8'h5A, 32'd0, 6'd9, 1'b0);
        // drain the short sleepers over three ticks
        add_tick(1'b0);
        add_tick(1'b0);
        add_tick(1'b0);

        // random: segments with their own tick density so the queue swings
        // between empty and full; small durations keep the wake runs long
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(15, 40);
                case ($urandom_range(0, 3))
                    0: tick_pct = 10;
                    1: tick_pct = 30;
                    2: tick_pct = 50;
                    default: tick_pct = 70;
                endcase
            end
            seg_left--;
            if ($urandom_range(0, 99) < tick_pct) begin
                add_tick(k == 0 || k == 100 || k == 160);
            end else begin
                logic [31:0] dur;
                logic [5:0]  prio;
                case ($urandom_range(0, 199))
                    0, 1:                dur = $urandom;            // parks for good
                    2, 3, 4, 5, 6, 7, 8: dur = '0;
                    default:             dur = $urandom_range(1, $urandom_range(1, 12));
                endcase
                // narrow priorities half the time to force ties
                prio = 6'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 63));
                add_req(swtq_pkg::ACT_SLEEP, 8'($urandom_range(0, 255)), dur, prio,
                        k == 0 || k == 100 || k == 160);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything offered and taken, then everything owed has arrived
        while (stim_q.size() > 0 || i_s_tvalid)
            @(posedge i_clk);
        while (n_predicted != n_checked)
            @(posedge i_clk);
        // a stray late result would still be caught by the monitor here
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run: %0d transactions, %0d ticks, %0d sleeps (%0d zero length)",
                 n_accepted, n_ticks, n_sleeps, n_zero);
        $display("run: %0d wakeups, %0d rejections on a full queue, longest wake run %0d",
                 n_wakes, n_rejects, longest_run);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/swtq_pkg.sv
sv/swtq_entry_ram.sv
sv/swtq_alu.sv
sv/sorted_wakeup_timer_queue_top.sv
sv/swtq_checker.sv
sim/sorted_wakeup_timer_queue_top_tb.sv
